// ===== rtl/tts_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Tick task scheduler package
// Shared types, codes and constants for the slot table, its walker and the
// top level.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int unsigned TaskSlotsDef = 48;
  localparam int unsigned SlotW        = 6;
  localparam int unsigned CodeW        = 16;
  localparam int unsigned TicksW       = 16;
  localparam int unsigned CdW          = 18;
  localparam int unsigned PendW        = 8;
  localparam int unsigned StatW        = 3;

  localparam logic [CodeW-1:0]  WarnCodeRst = 16'd1;
  localparam logic [TicksW-1:0] WarnHoldRst = 16'd2000;
  localparam logic [PendW-1:0]  PendMax     = 8'd255;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_ADD  = 2'd1,
    OP_DEL  = 2'd2,
    OP_DISP = 2'd3
  } op_e;

  typedef enum logic [StatW-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BAD_IDX  = 3'd3,
    ST_NONE_DUE = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    CFG_WARN_CODE = 1'b0,
    CFG_WARN_HOLD = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DEL,
    S_FIN
  } state_e;

  // One table entry. A code of zero marks a free slot.
  typedef struct packed {
    logic [CodeW-1:0]      code;
    logic signed [CdW-1:0] cd;
    logic [TicksW-1:0]     period;
    logic [PendW-1:0]      pend;
  } slot_t;

  typedef struct packed {
    logic             rd_en;
    logic [SlotW-1:0] rd_addr;
    logic             wr_en;
    logic [SlotW-1:0] wr_addr;
    slot_t            wr_data;
    logic             clr_en;
    logic [SlotW-1:0] clr_addr;
  } mem_cmd_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [SlotW-1:0] slot;
    logic [CodeW-1:0] code;
    logic             run;
    logic             warn;
    logic             last;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/tts_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Slot table memory
// Single-port-write, single-port-read synchronous table with registered read
// data. A valid bit per slot makes unwritten or cleared slots read
// as all zero without a clearing pass.
// ----------------------------------------------------------------------------
module tts_mem #(
  parameter int unsigned SLOTS = tts_pkg::TaskSlotsDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire tts_pkg::mem_cmd_t cmd_i,
  output tts_pkg::slot_t        rd_data_o
);
  import tts_pkg::*;

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  slot_t            mem_q [SLOTS];
  slot_t            rd_q;
  logic             rv_q;
  logic [SLOTS-1:0] vld_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[cmd_i.wr_addr[IW-1:0]] <= cmd_i.wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[cmd_i.rd_addr[IW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      rv_q  <= 1'b0;
    end else begin
      if (cmd_i.wr_en) begin
        vld_q[cmd_i.wr_addr[IW-1:0]] <= 1'b1;
      end
      if (cmd_i.clr_en) begin
        vld_q[cmd_i.clr_addr[IW-1:0]] <= 1'b0;
      end
      if (cmd_i.rd_en) begin
        rv_q <= vld_q[cmd_i.rd_addr[IW-1:0]];
      end
    end
  end

  assign rd_data_o = rv_q ? rd_q : '0;

endmodule
`default_nettype wire

// ===== rtl/tts_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Slot walker
// Sequencer that walks the slot table one entry per cycle unless dispatch output
// stalls, reads the next slot while writing back the current one, forms results.
// ----------------------------------------------------------------------------
module tts_ctrl #(
  parameter int unsigned SLOTS = tts_pkg::TaskSlotsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire tts_pkg::op_e                  op_i,
  input  wire logic [tts_pkg::CodeW-1:0]     code_i,
  input  wire logic [tts_pkg::TicksW-1:0]    phase_i,
  input  wire logic [tts_pkg::TicksW-1:0]    period_i,
  input  wire logic [tts_pkg::SlotW-1:0]     idx_i,
  input  wire logic [tts_pkg::CodeW-1:0]     warn_code_i,
  input  wire logic [tts_pkg::TicksW-1:0]    warn_hold_i,
  output tts_pkg::mem_cmd_t                  mem_cmd_o,
  input  wire tts_pkg::slot_t                rd_data_i,
  input  wire logic                          out_free_i,
  output logic                               out_push_o,
  output tts_pkg::result_t                   out_res_o
);
  import tts_pkg::*;

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  state_e             state_q, state_d;
  op_e                op_q;
  logic [CodeW-1:0]   code_q;
  logic [TicksW-1:0]  phase_q;
  logic [TicksW-1:0]  period_q;
  logic [SlotW-1:0]   idx_q;
  logic               load;

  logic [IW-1:0]      rp_q, rp_d;
  logic               rmore_q, rmore_d;
  logic [IW-1:0]      pidx_q, pidx_d;
  logic [IW-1:0]      ff_q, ff_d;
  logic               ff_found_q, ff_found_d;
  logic               hold_vld_q, hold_vld_d;
  logic [SlotW-1:0]   hold_slot_q, hold_slot_d;
  logic [CodeW-1:0]   hold_code_q, hold_code_d;
  logic               ovf_q, ovf_d;
  logic [StatW-1:0]   dstat_q, dstat_d;

  slot_t                 e;
  slot_t                 upd;
  logic                  due;
  logic                  advance;
  logic signed [CdW-1:0] cd_dec;
  logic [PendW-1:0]      pend_inc;

  assign e          = rd_data_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rp_q        <= '0;
      rmore_q     <= 1'b0;
      pidx_q      <= '0;
      ff_q        <= '0;
      ff_found_q  <= 1'b0;
      hold_vld_q  <= 1'b0;
      ovf_q       <= 1'b0;
      dstat_q     <= ST_OK;
    end else begin
      state_q     <= state_d;
      rp_q        <= rp_d;
      rmore_q     <= rmore_d;
      pidx_q      <= pidx_d;
      ff_q        <= ff_d;
      ff_found_q  <= ff_found_d;
      hold_vld_q  <= hold_vld_d;
      ovf_q       <= ovf_d;
      dstat_q     <= dstat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      op_q     <= op_i;
      code_q   <= code_i;
      phase_q  <= phase_i;
      period_q <= period_i;
      idx_q    <= idx_i;
    end
    hold_slot_q <= hold_slot_d;
    hold_code_q <= hold_code_d;
  end

  always_comb begin
    state_d     = state_q;
    rp_d        = rp_q;
    rmore_d     = rmore_q;
    pidx_d      = pidx_q;
    ff_d        = ff_q;
    ff_found_d  = ff_found_q;
    hold_vld_d  = hold_vld_q;
    hold_slot_d = hold_slot_q;
    hold_code_d = hold_code_q;
    ovf_d       = ovf_q;
    dstat_d     = dstat_q;
    load        = 1'b0;
    mem_cmd_o   = '0;
    out_push_o  = 1'b0;
    out_res_o   = '0;
    advance     = 1'b1;
    upd         = e;

    due      = (e.pend != '0);
    cd_dec   = (e.cd > -18'sd1) ? (e.cd - 18'sd1) : e.cd;
    pend_inc = (e.pend != PendMax) ? (e.pend + 8'd1) : e.pend;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          load = 1'b1;
          if (op_i == OP_DEL) begin
            if (int'(idx_i) >= SLOTS) begin
              dstat_d = ST_BAD_IDX;
              state_d = S_FIN;
            end else begin
              mem_cmd_o.rd_en   = 1'b1;
              mem_cmd_o.rd_addr = idx_i;
              state_d           = S_DEL;
            end
          end else begin
            mem_cmd_o.rd_en   = 1'b1;
            mem_cmd_o.rd_addr = '0;
            pidx_d            = '0;
            rp_d              = IW'(1);
            rmore_d           = (SLOTS > 1);
            ff_found_d        = 1'b0;
            hold_vld_d        = 1'b0;
            state_d           = S_WALK;
          end
        end
      end

      S_DEL: begin
        if (e.code != '0) begin
          dstat_d            = ST_OK;
          mem_cmd_o.clr_en   = 1'b1;
          mem_cmd_o.clr_addr = idx_q;
        end else begin
          dstat_d = ST_EMPTY;
        end
        state_d = S_FIN;
      end

      S_WALK: begin
        case (op_q)
          OP_TICK: begin
            if (e.code != '0) begin
              upd.cd = cd_dec;
              if (cd_dec <= 18'sd0) begin
                upd.pend = pend_inc;
                if (pend_inc > 8'd1) begin
                  ovf_d = 1'b1;
                end
                if (e.period != '0) begin
                  upd.cd = signed'({2'b00, e.period});
                end
              end
              mem_cmd_o.wr_en   = 1'b1;
              mem_cmd_o.wr_addr = SlotW'(pidx_q);
              mem_cmd_o.wr_data = upd;
            end
          end
          OP_ADD: begin
            if (e.code == '0 && !ff_found_q) begin
              ff_d       = pidx_q;
              ff_found_d = 1'b1;
            end
          end
          OP_DISP: begin
            // The previous due slot goes out only once another one follows,
            // so that the final one can carry the last flag.
            if (due && hold_vld_q) begin
              advance           = out_free_i;
              out_push_o        = out_free_i;
              out_res_o.status  = ST_OK;
              out_res_o.slot    = hold_slot_q;
              out_res_o.code    = hold_code_q;
              out_res_o.run     = 1'b1;
            end
            if (advance) begin
              if (due) begin
                hold_vld_d  = 1'b1;
                hold_slot_d = SlotW'(pidx_q);
                hold_code_d = e.code;
                if (e.period == '0) begin
                  mem_cmd_o.clr_en   = 1'b1;
                  mem_cmd_o.clr_addr = SlotW'(pidx_q);
                end else begin
                  upd.pend          = e.pend - 8'd1;
                  mem_cmd_o.wr_en   = 1'b1;
                  mem_cmd_o.wr_addr = SlotW'(pidx_q);
                  mem_cmd_o.wr_data = upd;
                end
              end
              if (((due && e.period == '0) || e.code == '0) && !ff_found_q) begin
                ff_d       = pidx_q;
                ff_found_d = 1'b1;
              end
            end
          end
          default: ;
        endcase

        if (advance) begin
          if (rmore_q) begin
            mem_cmd_o.rd_en   = 1'b1;
            mem_cmd_o.rd_addr = SlotW'(rp_q);
            pidx_d            = rp_q;
            rp_d              = rp_q + IW'(1);
            rmore_d           = (rp_q != IW'(SLOTS - 1));
          end else begin
            state_d = S_FIN;
          end
        end
      end

      S_FIN: begin
        if (out_free_i) begin
          out_push_o     = 1'b1;
          out_res_o.last = 1'b1;
          state_d        = S_IDLE;
          case (op_q)
            OP_TICK: begin
              out_res_o.status = ST_OK;
            end
            OP_ADD: begin
              if (ff_found_q) begin
                out_res_o.status          = ST_OK;
                out_res_o.slot            = SlotW'(ff_q);
                mem_cmd_o.wr_en           = 1'b1;
                mem_cmd_o.wr_addr         = SlotW'(ff_q);
                mem_cmd_o.wr_data.code    = code_q;
                mem_cmd_o.wr_data.cd      = signed'({2'b00, phase_q} + 18'd1);
                mem_cmd_o.wr_data.period  = period_q;
                mem_cmd_o.wr_data.pend    = '0;
              end else begin
                out_res_o.status = ST_FULL;
              end
            end
            OP_DEL: begin
              out_res_o.status = dstat_q;
              out_res_o.slot   = idx_q;
            end
            OP_DISP: begin
              if (hold_vld_q) begin
                out_res_o.status = ST_OK;
                out_res_o.slot   = hold_slot_q;
                out_res_o.code   = hold_code_q;
                out_res_o.run    = 1'b1;
              end else begin
                out_res_o.status = ST_NONE_DUE;
              end
              out_res_o.warn = ovf_q;
              // The warning-off task is dropped when no slot is free.
              if (ovf_q && ff_found_q) begin
                mem_cmd_o.wr_en          = 1'b1;
                mem_cmd_o.wr_addr        = SlotW'(ff_q);
                mem_cmd_o.wr_data.code   = warn_code_i;
                mem_cmd_o.wr_data.cd     = signed'({2'b00, warn_hold_i} + 18'd1);
                mem_cmd_o.wr_data.period = '0;
                mem_cmd_o.wr_data.pend   = '0;
              end
              ovf_d = 1'b0;
            end
            default: ;
          endcase
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/tick_task_scheduler_table.sv =====
`default_nettype none
// Requests: tick, add and dispatch walk the whole table before the last result;
// delete reads only the named slot (none for an index beyond the table).
// Throughput: one request at a time; the table walk reads one slot per cycle
// from the single read port; a new request waits until the last result is pushed.
// Dispatch results may stall the walk when the output is not taken.
// Reset clears every slot at once through per-slot valid bits; no sweep.
// ----------------------------------------------------------------------------
// Tick task scheduler table
// Time-triggered cooperative task table with tick, add, delete and dispatch
// requests, configuration registers and a registered result stage.
// ----------------------------------------------------------------------------
module tick_task_scheduler_table #(
  parameter int unsigned TASK_SLOTS = tts_pkg::TaskSlotsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write port.
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  // Request stream.
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // task_code[15:0], phase_ticks[31:16], period_ticks[47:32],
  // slot_index[53:48], zero[55:54]
  input  wire logic [55:0] s_axis_tdata_i,
  // op[1:0]
  input  wire logic [1:0]  s_axis_tuser_i,
  // Result stream.
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // slot_out[5:0], run_code[21:6], zero[23:22]
  output logic [23:0]      m_axis_tdata_o,
  // status[2:0], run_now[3], warning_on[4]
  output logic [4:0]       m_axis_tuser_o,
  output logic             m_axis_tlast_o
);
  import tts_pkg::*;

  logic [CodeW-1:0]  warn_code_q;
  logic [TicksW-1:0] warn_hold_q;

  logic      out_vld_q;
  result_t   out_q;
  logic      out_free;
  logic      out_push;
  result_t   out_res;
  mem_cmd_t  mem_cmd;
  slot_t     rd_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warn_code_q <= WarnCodeRst;
      warn_hold_q <= WarnHoldRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_WARN_CODE: warn_code_q <= cfg_wdata_i;
        CFG_WARN_HOLD: warn_hold_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  tts_mem #(
    .SLOTS (TASK_SLOTS)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (mem_cmd),
    .rd_data_o (rd_data)
  );

  tts_ctrl #(
    .SLOTS (TASK_SLOTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .op_i        (op_e'(s_axis_tuser_i)),
    .code_i      (s_axis_tdata_i[15:0]),
    .phase_i     (s_axis_tdata_i[31:16]),
    .period_i    (s_axis_tdata_i[47:32]),
    .idx_i       (s_axis_tdata_i[53:48]),
    .warn_code_i (warn_code_q),
    .warn_hold_i (warn_hold_q),
    .mem_cmd_o   (mem_cmd),
    .rd_data_i   (rd_data),
    .out_free_i  (out_free),
    .out_push_o  (out_push),
    .out_res_o   (out_res)
  );

  // The result register frees itself in the same cycle it is taken.
  assign out_free = !out_vld_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_push) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_push) begin
      out_q <= out_res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {2'b00, out_q.code, out_q.slot};
  assign m_axis_tuser_o  = {out_q.warn, out_q.run, out_q.status};
  assign m_axis_tlast_o  = out_q.last;

endmodule
`default_nettype wire

// ===== tb/sv/tick_task_scheduler_table_tb.sv =====
// ----------------------------------------------------------------------------
// Tick task scheduler table testbench
// Drives tick, add, delete and dispatch requests into the scheduler and checks
// every result against a behavioural copy of the slot table, or, for the typed
// rows of a directed table that covers the boundary cases, against the row
// itself. Random phases then fill the table, stall the result stream, tick the
// one-shot countdowns to their floor and change the configuration in between.
// ----------------------------------------------------------------------------
module tick_task_scheduler_table_tb;
  import tts_pkg::*;

  localparam int unsigned SLOTS       = TaskSlotsDef;
  localparam int          STALL_LIMIT = 20000;
  localparam int          RX_HOLD     = 600;
  localparam int          N_DIR       = 23;

  typedef struct packed {
    op_e         op;
    logic [15:0] code;
    logic [15:0] phase;
    logic [15:0] period;
    logic [5:0]  idx;
  } sched_req_t;

  typedef struct {
    op_e         op;
    logic [15:0] code;
    logic [15:0] phase;
    logic [15:0] period;
    logic [5:0]  idx;
    bit          typed;
    status_e     st;
    logic [5:0]  slot;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_idx;
  logic [15:0] cfg_wdata;
  logic        s_valid;
  logic        s_ready;
  logic [55:0] s_data;
  logic [1:0]  s_user;
  logic        m_valid;
  logic        rx_ready;
  logic [23:0] m_data;
  logic [4:0]  m_user;
  logic        m_last;

  // Behavioural copy of the slot table and its registers.
  logic [15:0]        tab_code   [SLOTS];
  logic signed [17:0] tab_cd     [SLOTS];
  logic [15:0]        tab_period [SLOTS];
  logic [7:0]         tab_pend   [SLOTS];
  bit                 tab_ovf;
  logic [15:0]        warn_code;
  logic [15:0]        warn_hold;

  result_t step_res [$];
  result_t sched_res_q [$];
  int      n_fail;
  int      idle_cycles;
  int      burst_left;
  bit      no_gap;
  bit      rx_hold_req;
  int      rx_phase;

  dir_row_t dir_tab [N_DIR] = '{
    '{OP_DISP, 16'h0000, 16'h0000, 16'h0000, 6'd0,  1'b1, ST_NONE_DUE, 6'd0},
    '{OP_DEL,  16'hffff, 16'hffff, 16'hffff, 6'd63, 1'b1, ST_BAD_IDX,  6'd63},
    '{OP_DEL,  16'h0000, 16'h0000, 16'h0000, 6'd48, 1'b1, ST_BAD_IDX,  6'd48},
    '{OP_DEL,  16'h0000, 16'h0000, 16'h0000, 6'd47, 1'b1, ST_EMPTY,    6'd47},
    '{OP_DEL,  16'h0000, 16'h0000, 16'h0000, 6'd0,  1'b1, ST_EMPTY,    6'd0},
    '{OP_TICK, 16'hffff, 16'hffff, 16'hffff, 6'd63, 1'b1, ST_OK,       6'd0},
    '{OP_ADD,  16'hffff, 16'h0000, 16'h0000, 6'd0,  1'b1, ST_OK,       6'd0},
    '{OP_ADD,  16'h0000, 16'h0005, 16'h0005, 6'd0,  1'b1, ST_OK,       6'd1},
    '{OP_ADD,  16'h1234, 16'hffff, 16'hffff, 6'd63, 1'b1, ST_OK,       6'd1},
    '{OP_ADD,  16'h0001, 16'h0001, 16'h0001, 6'd0,  1'b1, ST_OK,       6'd2},
    '{OP_ADD,  16'h8000, 16'h0000, 16'h0003, 6'd0,  1'b1, ST_OK,       6'd3},
    '{OP_TICK, 16'h0000, 16'h0000, 16'h0000, 6'd0,  1'b1, ST_OK,       6'd0},
    '{OP_TICK, 16'h0000, 16'h0000, 16'h0000, 6'd0,  1'b1, ST_OK,       6'd0},
    '{OP_DISP, 16'hffff, 16'hffff, 16'hffff, 6'd63, 1'b0, ST_OK,       6'd0},
    '{OP_DISP, 16'h0000, 16'h0000, 16'h0000, 6'd0,  1'b0, ST_OK,       6'd0},
    '{OP_TICK, 16'h0000, 16'h0000, 16'h0000, 6'd0,  1'b1, ST_OK,       6'd0},
    '{OP_TICK, 16'h0000, 16'h0000, 16'h0000, 6'd0,  1'b1, ST_OK,       6'd0},
    '{OP_TICK, 16'h0000, 16'h0000, 16'h0000, 6'd0,  1'b1, ST_OK,       6'd0},
    '{OP_DISP, 16'h0000, 16'h0000, 16'h0000, 6'd0,  1'b0, ST_OK,       6'd0},
    '{OP_DEL,  16'h0000, 16'h0000, 16'h0000, 6'd3,  1'b1, ST_OK,       6'd3},
    '{OP_DEL,  16'h0000, 16'h0000, 16'h0000, 6'd3,  1'b1, ST_EMPTY,    6'd3},
    '{OP_DEL,  16'h0000, 16'h0000, 16'h0000, 6'd1,  1'b1, ST_OK,       6'd1},
    '{OP_DISP, 16'h0000, 16'h0000, 16'h0000, 6'd0,  1'b0, ST_OK,       6'd0}
  };

  tick_task_scheduler_table #(
    .TASK_SLOTS(SLOTS)
  ) u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(rx_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tuser_o (m_user),
    .m_axis_tlast_o (m_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int place_task(input logic [15:0] code, input logic [15:0] phase,
                                    input logic [15:0] period);
    for (int i = 0; i < SLOTS; i++) begin
      if (tab_code[i] == 16'd0) begin
        tab_code[i]   = code;
        tab_cd[i]     = $signed({2'b00, phase}) + 18'sd1;
        tab_period[i] = period;
        tab_pend[i]   = 8'd0;
        return i;
      end
    end
    return -1;
  endfunction

  function automatic void free_slot(input int i);
    tab_code[i]   = '0;
    tab_cd[i]     = '0;
    tab_period[i] = '0;
    tab_pend[i]   = '0;
  endfunction

  // Applies one request to the table copy and leaves its results in step_res.
  function automatic void sched_step(input sched_req_t r);
    result_t res;
    int      s;
    step_res.delete();
    res = '0;
    res.status = ST_OK;
    res.last   = 1'b1;
    case (r.op)
      OP_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (tab_code[i] != 16'd0) begin
            if (tab_cd[i] > -18'sd1) tab_cd[i] = tab_cd[i] - 18'sd1;
            if (tab_cd[i] <= 18'sd0) begin
              if (tab_pend[i] < PendMax) tab_pend[i] = tab_pend[i] + 8'd1;
              if (tab_pend[i] > 8'd1) tab_ovf = 1'b1;
              if (tab_period[i] != 16'd0) tab_cd[i] = $signed({2'b00, tab_period[i]});
            end
          end
        end
        step_res.push_back(res);
      end
      OP_ADD: begin
        s = place_task(r.code, r.phase, r.period);
        if (s < 0) res.status = ST_FULL;
        else res.slot = s[5:0];
        step_res.push_back(res);
      end
      OP_DEL: begin
        res.slot = r.idx;
        if (r.idx >= SLOTS) res.status = ST_BAD_IDX;
        else if (tab_code[r.idx] == 16'd0) res.status = ST_EMPTY;
        else free_slot(r.idx);
        step_res.push_back(res);
      end
      default: begin
        res.last = 1'b0;
        res.run  = 1'b1;
        for (int i = 0; i < SLOTS; i++) begin
          if (tab_pend[i] > 8'd0) begin
            res.slot = i[5:0];
            res.code = tab_code[i];
            step_res.push_back(res);
            tab_pend[i] = tab_pend[i] - 8'd1;
            if (tab_period[i] == 16'd0) free_slot(i);
          end
        end
        if (step_res.size() == 0) begin
          res = '0;
          res.status = ST_NONE_DUE;
          step_res.push_back(res);
        end
        res = step_res.pop_back();
        res.last = 1'b1;
        if (tab_ovf) begin
          res.warn = 1'b1;
          s = place_task(warn_code, warn_hold, 16'd0);
          tab_ovf = 1'b0;
        end
        step_res.push_back(res);
      end
    endcase
  endfunction

  function automatic sched_req_t rand_add();
    sched_req_t r;
    r.op     = OP_ADD;
    r.code   = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
    r.phase  = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5: r.period = 16'd0;
      6, 7, 8:          r.period = 16'($urandom);
      default:          r.period = 16'($urandom_range(1, 8));
    endcase
    r.idx    = 6'($urandom);
    return r;
  endfunction

  function automatic sched_req_t rand_req();
    sched_req_t r;
    int         pick;
    pick     = $urandom_range(0, 99);
    r.code   = 16'($urandom);
    r.phase  = 16'($urandom);
    r.period = 16'($urandom);
    r.idx    = ($urandom_range(0, 6) == 0) ? 6'($urandom_range(48, 63))
                                           : 6'($urandom_range(0, 47));
    if (pick < 35) r.op = OP_TICK;
    else if (pick < 60) r = rand_add();
    else if (pick < 80) r.op = OP_DEL;
    else r.op = OP_DISP;
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_req(input sched_req_t r, input bit typed, input result_t typed_res);
    int gap;
    if (burst_left == 0) begin
      gap        = no_gap ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 8);
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    s_valid <= 1'b1;
    s_data  <= {2'b00, r.idx, r.period, r.phase, r.code};
    s_user  <= r.op;
    do @(posedge clk); while (!s_ready);
    burst_left--;
    sched_step(r);
    if (typed) sched_res_q.push_back(typed_res);
    else foreach (step_res[k]) sched_res_q.push_back(step_res[k]);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_valid <= 1'b0;
    while (sched_res_q.size() != 0) @(negedge clk);
    repeat (SLOTS + 4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_WARN_CODE) warn_code = val;
    else warn_hold = val;
  endtask

  task automatic run_mixed(input int n);
    for (int k = 0; k < n; k++) send_req(rand_req(), 1'b0, '0);
  endtask

  // Result stream: the ready pattern steps through four modes as rx_phase counts,
  // and a long hold-off can be requested by the stimulus process.
  initial begin
    rx_ready <= 1'b0;
    rx_phase = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_ready <= 1'b0;
        repeat (RX_HOLD) @(negedge clk);
        rx_hold_req = 1'b0;
      end else begin
        rx_phase++;
        case ((rx_phase / 256) % 4)
          0:       rx_ready <= 1'b1;
          1:       rx_ready <= 1'($urandom_range(0, 1));
          2:       rx_ready <= ($urandom_range(0, 3) == 0);
          default: rx_ready <= ((rx_phase % 5) < 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && m_valid && rx_ready) begin
      got.status = m_user[2:0];
      got.run    = m_user[3];
      got.warn   = m_user[4];
      got.slot   = m_data[5:0];
      got.code   = m_data[21:6];
      got.last   = m_last;
      if (sched_res_q.size() == 0) begin
        $display("%0t: result with none expected: status %0d slot %0d code %h",
                 $time, got.status, got.slot, got.code);
        n_fail++;
      end else begin
        want = sched_res_q.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          n_fail++;
        end
        if (got.slot !== want.slot) begin
          $display("%0t: slot_out expected %0d actual %0d", $time, want.slot, got.slot);
          n_fail++;
        end
        if (got.code !== want.code) begin
          $display("%0t: run_code expected %h actual %h", $time, want.code, got.code);
          n_fail++;
        end
        if (got.run !== want.run) begin
          $display("%0t: run_now expected %b actual %b", $time, want.run, got.run);
          n_fail++;
        end
        if (got.warn !== want.warn) begin
          $display("%0t: warning_on expected %b actual %b", $time, want.warn, got.warn);
          n_fail++;
        end
        if (got.last !== want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last, got.last);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (s_valid && s_ready) || (m_valid && rx_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tick_task_scheduler_table test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    result_t    typed_res;
    sched_req_t r;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_idx   <= 1'b0;
    cfg_wdata <= '0;
    s_valid   <= 1'b0;
    s_data    <= '0;
    s_user    <= '0;
    n_fail      = 0;
    idle_cycles = 0;
    burst_left  = 0;
    no_gap      = 1'b0;
    rx_hold_req = 1'b0;
    tab_ovf     = 1'b0;
    warn_code   = WarnCodeRst;
    warn_hold   = WarnHoldRst;
    for (int i = 0; i < SLOTS; i++) free_slot(i);
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int k = 0; k < N_DIR; k++) begin
      r = '{op: dir_tab[k].op, code: dir_tab[k].code, phase: dir_tab[k].phase,
            period: dir_tab[k].period, idx: dir_tab[k].idx};
      typed_res        = '0;
      typed_res.status = dir_tab[k].st;
      typed_res.slot   = dir_tab[k].slot;
      typed_res.last   = 1'b1;
      send_req(r, dir_tab[k].typed, typed_res);
    end
    run_mixed(20);

    // A zero hold makes the warning-off task due on the very next tick.
    write_reg(CFG_WARN_CODE, 16'hffff);
    write_reg(CFG_WARN_HOLD, 16'd0);
    for (int k = 0; k < 50; k++) send_req(rand_add(), 1'b0, '0);
    run_mixed(5);

    // Hold the result stream off while requests keep coming, so that a
    // dispatch over a full table backs up into the request side.
    wait_drained();
    no_gap      = 1'b1;
    rx_hold_req = 1'b1;
    for (int k = 0; k < 4; k++) send_req('{OP_TICK, 16'($urandom), 16'h0, 16'h0, 6'h0},
                                         1'b0, '0);
    send_req('{OP_DISP, 16'h0, 16'h0, 16'h0, 6'h0}, 1'b0, '0);
    run_mixed(8);
    no_gap = 1'b0;

    write_reg(CFG_WARN_CODE, 16'($urandom_range(1, 65535)));
    write_reg(CFG_WARN_HOLD, 16'hffff);
    for (int k = 0; k < 2; k++) send_req(rand_add(), 1'b0, '0);
    // A run of ticks with no dispatch piles up pending runs and drives the
    // one-shot countdowns down to their floor.
    no_gap = 1'b1;
    for (int k = 0; k < 8; k++) send_req('{OP_TICK, 16'($urandom), 16'($urandom),
                                           16'($urandom), 6'($urandom)}, 1'b0, '0);
    no_gap = 1'b0;
    send_req('{OP_DISP, 16'h0, 16'h0, 16'h0, 6'h0}, 1'b0, '0);
    run_mixed(5);

    write_reg(CFG_WARN_CODE, 16'd1);
    write_reg(CFG_WARN_HOLD, 16'($urandom_range(0, 20)));
    run_mixed(5);

    wait_drained();
    repeat (2 * SLOTS) @(posedge clk);
    if (n_fail == 0) begin
      $display("tick_task_scheduler_table test passed");
    end else begin
      $display("tick_task_scheduler_table test failed");
    end
    $finish;
  end

endmodule
